FILE: rtl/lps_pkg.sv
// lps_pkg: shared types and constants of the line point stepper.
// No dependencies; imported by every module under rtl/.
package lps_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int MAX_STEPS_DEF  = 16;

  // configuration register
  localparam int            CFG_W       = 5;
  localparam logic [CFG_W-1:0] STEPS_RESET = 5'd16;
  // width used to compare the register with MAX_STEPS (valid for MAX_STEPS up to 127)
  localparam int            STEP_CMP_W  = 7;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // heading frames; bit 7 marks a mirrored west-facing frame
  localparam int             FRAME_W  = 8;
  localparam logic [FRAME_W-1:0] FRAME_N  = 8'd0;
  localparam logic [FRAME_W-1:0] FRAME_NE = 8'd1;
  localparam logic [FRAME_W-1:0] FRAME_E  = 8'd2;
  localparam logic [FRAME_W-1:0] FRAME_SE = 8'd3;
  localparam logic [FRAME_W-1:0] FRAME_S  = 8'd4;
  localparam logic [FRAME_W-1:0] FRAME_NW = 8'd129;
  localparam logic [FRAME_W-1:0] FRAME_W_ = 8'd130;
  localparam logic [FRAME_W-1:0] FRAME_SW = 8'd131;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_EMIT
  } lps_state_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic load_start;  // start command: load source and target
    logic do_init;     // first tick: set up deltas, signs, frame
    logic do_step;     // one pixel step through the shared unit
    logic emit;        // load the output register
  } lps_ctl_t;

endpackage

FILE: rtl/lps_init_unit.sv
// lps_init_unit: line setup for the first tick after a start.
// Forms absolute deltas, step signs, heading frame and error seed.
// Depends on lps_pkg.
module lps_init_unit #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]         cur_x,
  input  logic [COORD_BITS-1:0]         cur_y,
  input  logic [COORD_BITS-1:0]         goal_x,
  input  logic [COORD_BITS-1:0]         goal_y,
  output logic                          at_goal,
  output logic [lps_pkg::FRAME_W-1:0]   frame,
  output logic [1:0]                    signs,
  output logic [COORD_BITS:0]           dx_out,
  output logic [COORD_BITS:0]           dy_out,
  output logic                          err_load,
  output logic signed [COORD_BITS+1:0]  err_out
);
  import lps_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic signed [CB:0] dxs, dys;
  logic [CB-1:0]      adx, ady, amax;
  logic               x_neg, y_neg, x_zero, y_zero;

  assign dxs    = signed'({1'b0, goal_x}) - signed'({1'b0, cur_x});
  assign dys    = signed'({1'b0, goal_y}) - signed'({1'b0, cur_y});
  assign x_neg  = dxs[CB];
  assign y_neg  = dys[CB];
  assign adx    = x_neg ? CB'(-dxs) : dxs[CB-1:0];
  assign ady    = y_neg ? CB'(-dys) : dys[CB-1:0];
  assign x_zero = (adx == '0);
  assign y_zero = (ady == '0);
  assign amax   = (adx < ady) ? ady : adx;

  assign at_goal = x_zero && y_zero;
  assign signs   = {y_neg, x_neg};

  always_comb begin
    if (x_zero) begin
      frame = y_neg ? FRAME_N : FRAME_S;
    end else if (!x_neg) begin
      frame = y_neg ? FRAME_NE : (y_zero ? FRAME_E : FRAME_SE);
    end else begin
      frame = y_neg ? FRAME_NW : (y_zero ? FRAME_W_ : FRAME_SW);
    end
  end

  // steep and shallow lines get doubled deltas and a fresh error seed
  assign err_load = !x_zero && !y_zero && (adx != ady);
  assign err_out  = signed'(EW'(amax)) - signed'(EW'(1));
  assign dx_out   = err_load ? {adx, 1'b0} : {1'b0, adx};
  assign dy_out   = err_load ? {ady, 1'b0} : {1'b0, ady};

endmodule

FILE: rtl/lps_step_unit.sv
// lps_step_unit: one Bresenham pixel step with arrival test, shared by
// every step of a tick. Depends on lps_pkg.
module lps_step_unit #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]         cur_x,
  input  logic [COORD_BITS-1:0]         cur_y,
  input  logic [COORD_BITS-1:0]         goal_x,
  input  logic [COORD_BITS-1:0]         goal_y,
  input  logic signed [COORD_BITS+1:0]  err_in,
  input  logic [COORD_BITS:0]           dx2,
  input  logic [COORD_BITS:0]           dy2,
  input  logic [1:0]                    signs,
  output logic                          hit,
  output logic [COORD_BITS-1:0]         nxt_x,
  output logic [COORD_BITS-1:0]         nxt_y,
  output logic signed [COORD_BITS+1:0]  nxt_err
);
  import lps_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 2;
  localparam logic [CB-1:0] ONE = CB'(1);

  logic [CB-1:0]      mv_x, mv_y;
  logic               dx_zero, dy_zero, y_major, x_major;
  logic signed [EW-1:0] sub_op, add_op, e1, e2;

  assign mv_x    = signs[0] ? (cur_x - ONE) : (cur_x + ONE);
  assign mv_y    = signs[1] ? (cur_y - ONE) : (cur_y + ONE);
  assign dx_zero = (dx2 == '0);
  assign dy_zero = (dy2 == '0);
  assign y_major = (dx2 < dy2);
  assign x_major = (dx2 > dy2);

  // one subtract, then correction by the major delta
  assign sub_op = y_major ? signed'(EW'(dx2)) : signed'(EW'(dy2));
  assign add_op = y_major ? signed'(EW'(dy2)) : signed'(EW'(dx2));
  assign e1     = err_in - sub_op;
  assign e2     = e1 + add_op;

  always_comb begin
    hit     = 1'b0;
    nxt_x   = cur_x;
    nxt_y   = cur_y;
    nxt_err = err_in;
    if (dy_zero) begin
      hit   = (cur_x == goal_x);
      nxt_x = mv_x;
    end else if (dx_zero) begin
      hit   = (cur_y == goal_y);
      nxt_y = mv_y;
    end else if (y_major) begin
      hit   = (cur_y == goal_y);
      nxt_y = mv_y;
      if (e1 < 0) begin
        nxt_err = e2;
        nxt_x   = mv_x;
      end else begin
        nxt_err = e1;
      end
    end else if (x_major) begin
      hit   = (cur_x == goal_x);
      nxt_x = mv_x;
      if (e1 < 0) begin
        nxt_err = e2;
        nxt_y   = mv_y;
      end else begin
        nxt_err = e1;
      end
    end else begin
      // diagonal: arrival on y only
      hit   = (cur_y == goal_y);
      nxt_x = mv_x;
      nxt_y = mv_y;
    end
  end

endmodule

FILE: rtl/lps_ctrl.sv
// lps_ctrl: sequencer and step counter of the line point stepper.
// Depends on lps_pkg.
module lps_ctrl #(
  parameter int MAX_STEPS = lps_pkg::MAX_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_cmd,
  input  logic                     initialized,
  input  logic                     step_hit,
  input  logic [lps_pkg::CFG_W-1:0] steps_cfg,
  input  logic                     out_busy,
  output logic                     in_ready,
  output lps_pkg::lps_ctl_t        ctl
);
  import lps_pkg::*;

  localparam int NW = (MAX_STEPS < 2) ? 1 : $clog2(MAX_STEPS + 1);

  lps_state_t          state_r, state_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic [NW-1:0]       n_steps;
  logic [STEP_CMP_W-1:0] cfg_ext;

  // zero acts as one, anything above MAX_STEPS as MAX_STEPS
  assign cfg_ext = STEP_CMP_W'(steps_cfg);
  always_comb begin
    if (steps_cfg == '0) begin
      n_steps = NW'(1);
    end else if (cfg_ext > STEP_CMP_W'(MAX_STEPS)) begin
      n_steps = NW'(MAX_STEPS);
    end else begin
      n_steps = cfg_ext[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          cnt_nxt    = '0;
          if (in_cmd == CMD_START) begin
            ctl.load_start = 1'b1;
            state_nxt      = ST_EMIT;
          end else if (!initialized) begin
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_INIT: begin
        ctl.do_init = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_STEP: begin
        ctl.do_step = 1'b1;
        if (step_hit || (cnt_r == n_steps - NW'(1))) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      ST_EMIT: begin
        if (!out_busy) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/line_point_stepper_core.sv
// line_point_stepper_core: moves a point from source to target pixel by
// Bresenham stepping, at most steps_per_tick pixels per tick.
// A start loads source and target, then emits; a tick while uninitialized
// runs the init state, then emits; later ticks run the step state until the
// target is found or steps_per_tick (clamped to 1..MAX_STEPS) steps are done;
// each step moves one pixel or finds the target. out_valid and in_ready rise
// in the same cycle; a result left waiting holds the block in its emit state.
// Reset: synchronous, active low rst_n; clears state, steps_per_tick = 16.
module line_point_stepper_core #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF,
  parameter int MAX_STEPS  = lps_pkg::MAX_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [lps_pkg::CFG_W-1:0]  cfg_wr_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [COORD_BITS-1:0]      in_src_x,
  input  logic [COORD_BITS-1:0]      in_src_y,
  input  logic [COORD_BITS-1:0]      in_dst_x,
  input  logic [COORD_BITS-1:0]      in_dst_y,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COORD_BITS-1:0]      out_pos_x,
  output logic [COORD_BITS-1:0]      out_pos_y,
  output logic                       out_arrived,
  output logic [lps_pkg::FRAME_W-1:0] out_heading_frame
);
  import lps_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  // configuration register
  logic [CFG_W-1:0] steps_cfg_r;

  // line state
  logic [CB-1:0]        cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic signed [EW-1:0] err_r;
  logic [CB:0]          dx2_r, dy2_r;
  logic [1:0]           signs_r;
  logic                 init_r;
  logic [FRAME_W-1:0]   frame_r;
  logic                 arrived_r;

  // output register
  logic                 out_valid_r;
  logic [CB-1:0]        out_x_r, out_y_r;
  logic                 out_arr_r;
  logic [FRAME_W-1:0]   out_frame_r;

  lps_ctl_t ctl;

  // setup results
  logic                 ini_at_goal, ini_err_load;
  logic [FRAME_W-1:0]   ini_frame;
  logic [1:0]           ini_signs;
  logic [CB:0]          ini_dx, ini_dy;
  logic signed [EW-1:0] ini_err;

  // step results
  logic                 stp_hit;
  logic [CB-1:0]        stp_x, stp_y;
  logic signed [EW-1:0] stp_err;

  lps_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_cmd      (in_cmd),
    .initialized (init_r),
    .step_hit    (stp_hit),
    .steps_cfg   (steps_cfg_r),
    .out_busy    (out_valid_r && !out_ready),
    .in_ready    (in_ready),
    .ctl         (ctl)
  );

  lps_init_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_init (
    .cur_x    (cur_x_r),
    .cur_y    (cur_y_r),
    .goal_x   (goal_x_r),
    .goal_y   (goal_y_r),
    .at_goal  (ini_at_goal),
    .frame    (ini_frame),
    .signs    (ini_signs),
    .dx_out   (ini_dx),
    .dy_out   (ini_dy),
    .err_load (ini_err_load),
    .err_out  (ini_err)
  );

  lps_step_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .cur_x   (cur_x_r),
    .cur_y   (cur_y_r),
    .goal_x  (goal_x_r),
    .goal_y  (goal_y_r),
    .err_in  (err_r),
    .dx2     (dx2_r),
    .dy2     (dy2_r),
    .signs   (signs_r),
    .hit     (stp_hit),
    .nxt_x   (stp_x),
    .nxt_y   (stp_y),
    .nxt_err (stp_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_cfg_r <= STEPS_RESET;
    end else if (cfg_wr_en) begin
      steps_cfg_r <= cfg_wr_data;
    end
  end

  // line state: start loads, first tick sets up, later ticks step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      goal_x_r  <= '0;
      goal_y_r  <= '0;
      err_r     <= '0;
      dx2_r     <= '0;
      dy2_r     <= '0;
      signs_r   <= '0;
      init_r    <= 1'b0;
      frame_r   <= '0;
      arrived_r <= 1'b0;
    end else begin
      if (ctl.accept) begin
        arrived_r <= 1'b0;
      end
      if (ctl.load_start) begin
        cur_x_r  <= in_src_x;
        cur_y_r  <= in_src_y;
        goal_x_r <= in_dst_x;
        goal_y_r <= in_dst_y;
        init_r   <= 1'b0;
        frame_r  <= '0;
      end
      if (ctl.do_init) begin
        frame_r <= ini_frame;
        if (ini_at_goal) begin
          // source equals target: arrived, stays uninitialized
          arrived_r <= 1'b1;
        end else begin
          dx2_r   <= ini_dx;
          dy2_r   <= ini_dy;
          signs_r <= ini_signs;
          init_r  <= 1'b1;
          if (ini_err_load) begin
            err_r <= ini_err;
          end
        end
      end
      if (ctl.do_step) begin
        if (stp_hit) begin
          arrived_r <= 1'b1;
        end else begin
          cur_x_r <= stp_x;
          cur_y_r <= stp_y;
          err_r   <= stp_err;
        end
      end
    end
  end

  // output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_arr_r   <= arrived_r;
      out_frame_r <= frame_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = out_x_r;
  assign out_pos_y         = out_y_r;
  assign out_arrived       = out_arr_r;
  assign out_heading_frame = out_frame_r;

endmodule
